// File: design/ikta_pkg.sv
// Shared types and constants of the interpolation kernel tap accumulator.
// Used by ikta_ctrl, ikta_dp and interp_kernel_tap_accumulator; depends on nothing.
package ikta_pkg;

	typedef struct packed {
		logic signed [15:0] offset_x;
		logic signed [15:0] offset_y;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic               tap_valid;
		logic               last_tap;
	} ikta_in_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
	} ikta_out_t;

	// Datapath operations, one per controller step.
	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_SQ, OP_CU, OP_PL, OP_D6, OP_WP, OP_PX,
		OP_PY, OP_MR, OP_MG, OP_MB, OP_DL, OP_DV, OP_OUT
	} ikta_op_t;

	typedef struct packed {
		ikta_op_t op;
		logic     axis_y;
	} ikta_cmd_t;

	typedef struct packed {
		logic take_ok;
		logic last_tap;
		logic out_full;
	} ikta_stat_t;

	localparam logic [1:0] REG_KERNEL_MODE = 2'd0;
	localparam logic [1:0] REG_DIRECTION   = 2'd1;
	localparam logic [1:0] REG_RADIUS      = 2'd2;

	localparam logic [1:0] MODE_BILINEAR = 2'd0;
	localparam logic [1:0] MODE_CUBIC    = 2'd1;
	localparam logic [1:0] MODE_LANCZOS  = 2'd2;
	localparam logic [1:0] MODE_BSPLINE  = 2'd3;

	// Division runs from quotient bit 8 (saturation) down to bit 0.
	localparam logic [3:0]  DIV_TOP_BIT = 4'd8;
	// ceil(2^20 / 3), exact for dividends below 2^19.
	localparam logic [18:0] RECIP3      = 19'd349526;
	localparam logic [14:0] RADIUS_RST  = 15'd4096;

	// Lanczos-2 samples in Q1.16 at steps of 1/16.
	function automatic logic [16:0] lz_tab(input logic [4:0] idx);
		logic [16:0] v;
		case (idx)
			5'd0:  v = 17'd65536;
			5'd1:  v = 17'd65011;
			5'd2:  v = 17'd63455;
			5'd3:  v = 17'd60922;
			5'd4:  v = 17'd57498;
			5'd5:  v = 17'd53302;
			5'd6:  v = 17'd48473;
			5'd7:  v = 17'd43170;
			5'd8:  v = 17'd37563;
			5'd9:  v = 17'd31822;
			5'd10: v = 17'd26116;
			5'd11: v = 17'd20604;
			5'd12: v = 17'd15424;
			5'd13: v = 17'd10695;
			5'd14: v = 17'd6510;
			5'd15: v = 17'd2934;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

endpackage

// File: design/ikta_ctrl.sv
// Sequencer of the interpolation kernel tap accumulator.
// Depends on ikta_pkg; drives ikta_dp through ikta_cmd_t.
module ikta_ctrl import ikta_pkg::*; #(
	parameter int MAX_TAPS = 49
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  ikta_stat_t stat,
	output ikta_cmd_t  cmd
);

	localparam int TW = $clog2(MAX_TAPS + 1);

	typedef enum logic [13:0] {
		ST_IDLE = 14'b00000000000001,
		ST_SQ   = 14'b00000000000010,
		ST_CU   = 14'b00000000000100,
		ST_PL   = 14'b00000000001000,
		ST_D6   = 14'b00000000010000,
		ST_WP   = 14'b00000000100000,
		ST_PX   = 14'b00000001000000,
		ST_PY   = 14'b00000010000000,
		ST_MR   = 14'b00000100000000,
		ST_MG   = 14'b00001000000000,
		ST_MB   = 14'b00010000000000,
		ST_DL   = 14'b00100000000000,
		ST_DV   = 14'b01000000000000,
		ST_OUT  = 14'b10000000000000
	} state_t;

	state_t          state_q, state_d;
	logic            axis_q, axis_d;
	logic            last_q, last_d;
	logic [TW-1:0]   taps_q, taps_d;
	logic [3:0]      cnt_q, cnt_d;
	logic            room;

	assign in_ready = (state_q == ST_IDLE);
	assign room     = (taps_q < TW'(MAX_TAPS));

	always_comb begin
		state_d = state_q;
		axis_d  = axis_q;
		last_d  = last_q;
		taps_d  = taps_q;
		cnt_d   = cnt_q;
		cmd.op  = OP_NONE;
		cmd.axis_y = axis_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op = OP_LOAD;
					last_d = stat.last_tap;
					axis_d = 1'b0;
					if (room) begin
						taps_d = taps_q + TW'(1);
					end
					if (room && stat.take_ok) begin
						state_d = ST_SQ;
					end else if (stat.last_tap) begin
						state_d = ST_DL;
					end
				end
			end
			ST_SQ: begin
				cmd.op  = OP_SQ;
				state_d = ST_CU;
			end
			ST_CU: begin
				cmd.op  = OP_CU;
				state_d = ST_PL;
			end
			ST_PL: begin
				cmd.op  = OP_PL;
				state_d = ST_D6;
			end
			ST_D6: begin
				cmd.op = OP_D6;
				if (axis_q) begin
					state_d = ST_WP;
				end else begin
					axis_d  = 1'b1;
					state_d = ST_SQ;
				end
			end
			ST_WP: begin
				cmd.op  = OP_WP;
				state_d = ST_PX;
			end
			ST_PX: begin
				cmd.op  = OP_PX;
				state_d = ST_PY;
			end
			ST_PY: begin
				cmd.op  = OP_PY;
				state_d = ST_MR;
			end
			ST_MR: begin
				cmd.op  = OP_MR;
				state_d = ST_MG;
			end
			ST_MG: begin
				cmd.op  = OP_MG;
				state_d = ST_MB;
			end
			ST_MB: begin
				cmd.op  = OP_MB;
				state_d = last_q ? ST_DL : ST_IDLE;
			end
			ST_DL: begin
				cmd.op  = OP_DL;
				cnt_d   = DIV_TOP_BIT;
				state_d = ST_DV;
			end
			ST_DV: begin
				cmd.op = OP_DV;
				cnt_d  = cnt_q - 4'd1;
				if (cnt_q == 4'd0) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!stat.out_full) begin
					cmd.op  = OP_OUT;
					taps_d  = '0;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= 1'b0;
			last_q  <= 1'b0;
			taps_q  <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			axis_q  <= axis_d;
			last_q  <= last_d;
			taps_q  <= taps_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

// File: design/ikta_dp.sv
// Datapath of the interpolation kernel tap accumulator: kernel evaluation on one
// shared multiplier, accumulators, three-lane divider and output register. Uses ikta_pkg.
module ikta_dp import ikta_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ikta_cmd_t   cmd,
	output ikta_stat_t  stat,
	input  ikta_in_t    in_data,
	input  logic        out_ready,
	output logic        out_valid,
	output ikta_out_t   out_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_data
);

	function automatic logic [16:0] mag16(input logic [15:0] raw);
		return raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
	endfunction

	logic [1:0]  mode_q;
	logic        dir_q;
	logic [14:0] radius_q;

	logic [16:0] ux_q, uy_q;
	logic [7:0]  col_q [3];
	logic [43:0] prod_q;
	logic [24:0] sq_q;
	logic [18:0] poly_q;
	logic [16:0] wx_q, wy_q, w_q;
	logic [31:0] sum_c_q [3];
	logic [23:0] sum_w_q;
	logic [32:0] rem_q [3];
	logic [8:0]  quo_q [3];
	logic [31:0] den_q;
	logic        out_valid_q;
	ikta_out_t   out_q;

	logic [16:0] in_ux, in_uy, u;
	logic        in_rng, v_low, px_en, py_en;
	logic [11:0] a, r;
	logic [12:0] v, b;
	logic [13:0] t_full;
	logic [16:0] tab_hi, tab_lo, d;
	logic [24:0] mul_a;
	logic [18:0] mul_b;
	logic [43:0] prod;
	logic [36:0] cube;
	logic [26:0] sq3;
	logic [39:0] num1, sum1, num3, sum3;
	logic [28:0] corr;
	logic [16:0] wt;
	logic [18:0] poly_d;
	logic [16:0] wt_axis;

	assign in_ux = mag16(in_data.offset_x);
	assign in_uy = mag16(in_data.offset_y);
	assign stat.take_ok  = in_data.tap_valid && (!dir_q ||
		(in_ux <= {2'b00, radius_q} && in_uy <= {2'b00, radius_q}));
	assign stat.last_tap = in_data.last_tap;
	assign stat.out_full = out_valid_q && !out_ready;

	// Per-axis kernel operands.
	assign u      = cmd.axis_y ? uy_q : ux_q;
	assign in_rng = (u[16:12] == 5'd0);
	assign a      = u[11:0];
	assign v      = {a, 1'b0};
	assign v_low  = !v[12];
	assign t_full = 14'd8192 - {1'b0, v};
	assign b      = (mode_q == MODE_BSPLINE) ? (v_low ? v : t_full[12:0]) : {1'b0, a};
	assign r      = {a[7:0], 4'b0000};
	assign tab_hi = lz_tab({1'b0, a[11:8]});
	assign tab_lo = lz_tab({1'b0, a[11:8]} + 5'd1);
	assign d      = tab_hi - tab_lo;
	assign px_en  = !dir_q && ux_q > 17'd2048 && ux_q < 17'd4096;
	assign py_en  = !dir_q && uy_q > 17'd2048 && uy_q < 17'd4096;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_SQ: begin
				mul_a = 25'(b);
				mul_b = 19'(b);
			end
			OP_CU: begin
				if (mode_q == MODE_LANCZOS) begin
					mul_a = 25'(d);
					mul_b = 19'(r);
				end else begin
					mul_a = prod_q[24:0];
					mul_b = 19'(b);
				end
			end
			OP_D6: begin
				mul_a = 25'(poly_q[18:1]);
				mul_b = RECIP3;
			end
			OP_WP: begin
				mul_a = 25'(wx_q);
				mul_b = 19'(wy_q);
			end
			OP_PX: begin
				mul_a = 25'(w_q);
				mul_b = 19'(13'd6144 - ux_q[12:0]);
			end
			OP_PY: begin
				mul_a = 25'(w_q);
				mul_b = 19'(13'd6144 - uy_q[12:0]);
			end
			OP_MR: begin
				mul_a = 25'(w_q);
				mul_b = 19'(col_q[0]);
			end
			OP_MG: begin
				mul_a = 25'(w_q);
				mul_b = 19'(col_q[1]);
			end
			OP_MB: begin
				mul_a = 25'(w_q);
				mul_b = 19'(col_q[2]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = 44'(mul_a) * 44'(mul_b);

	// Polynomial assembly from the registered square and cube.
	assign cube = prod_q[36:0];
	assign sq3  = (27'(sq_q) << 1) + 27'(sq_q);
	assign num1 = (40'(cube) << 1) + (40'd1 << 36) - (40'(sq3) << 12);
	assign sum1 = num1 + (40'd1 << 19);
	assign num3 = v_low ? (40'(cube) + (40'(cube) << 1) + (40'd1 << 38) - (40'(sq3) << 13))
		: 40'(cube);
	assign sum3 = num3 + (40'd3 << 20);
	assign corr = 29'(prod_q[27:0]) + 29'd2048;

	always_comb begin
		case (mode_q)
			MODE_BILINEAR: wt = {13'd4096 - {1'b0, a}, 4'b0000};
			MODE_CUBIC:    wt = sum1[36:20];
			MODE_LANCZOS:  wt = tab_hi - corr[28:12];
			default:       wt = '0;
		endcase
	end

	assign poly_d  = (mode_q == MODE_BSPLINE) ? sum3[38:20] : 19'(wt);
	assign wt_axis = !in_rng ? 17'd0 : (mode_q == MODE_BSPLINE) ? prod[36:20] : poly_q[16:0];

	// Payload registers.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				ux_q     <= in_ux;
				uy_q     <= in_uy;
				col_q[0] <= in_data.red;
				col_q[1] <= in_data.green;
				col_q[2] <= in_data.blue;
			end
			OP_SQ: prod_q <= prod;
			OP_CU: begin
				sq_q   <= prod_q[24:0];
				prod_q <= prod;
			end
			OP_PL: poly_q <= poly_d;
			OP_D6: begin
				if (cmd.axis_y) begin
					wy_q <= wt_axis;
				end else begin
					wx_q <= wt_axis;
				end
			end
			OP_WP: w_q <= 17'((prod + 44'd32768) >> 16);
			OP_PX: begin
				if (px_en) begin
					w_q <= 17'((prod + 44'd2048) >> 12);
				end
			end
			OP_PY: begin
				if (py_en) begin
					w_q <= 17'((prod + 44'd2048) >> 12);
				end
			end
			OP_DL: begin
				for (int i = 0; i < 3; i++) begin
					rem_q[i] <= {1'b0, sum_c_q[i]} + 33'(sum_w_q[23:1]);
					quo_q[i] <= '0;
				end
				den_q <= {sum_w_q, 8'd0};
			end
			OP_DV: begin
				for (int i = 0; i < 3; i++) begin
					if (rem_q[i] >= {1'b0, den_q}) begin
						rem_q[i] <= rem_q[i] - {1'b0, den_q};
						quo_q[i] <= {quo_q[i][7:0], 1'b1};
					end else begin
						quo_q[i] <= {quo_q[i][7:0], 1'b0};
					end
				end
				den_q <= den_q >> 1;
			end
			OP_OUT: begin
				if (sum_w_q == 24'd0) begin
					out_q <= '0;
				end else begin
					out_q.red_out   <= quo_q[0][8] ? 8'hFF : quo_q[0][7:0];
					out_q.green_out <= quo_q[1][8] ? 8'hFF : quo_q[1][7:0];
					out_q.blue_out  <= quo_q[2][8] ? 8'hFF : quo_q[2][7:0];
				end
			end
			default: begin
			end
		endcase
	end

	function automatic logic [31:0] sat_add32(input logic [31:0] s, input logic [24:0] x);
		logic [32:0] t;
		t = {1'b0, s} + 33'(x);
		return t[32] ? 32'hFFFF_FFFF : t[31:0];
	endfunction

	logic [24:0] sw_sum;
	assign sw_sum = {1'b0, sum_w_q} + 25'(w_q);

	// Configuration, accumulators and output handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_BILINEAR;
			dir_q       <= 1'b0;
			radius_q    <= RADIUS_RST;
			for (int i = 0; i < 3; i++) begin
				sum_c_q[i] <= '0;
			end
			sum_w_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_KERNEL_MODE: mode_q   <= cfg_data[1:0];
					REG_DIRECTION:   dir_q    <= cfg_data[0];
					REG_RADIUS:      radius_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				OP_MR: sum_c_q[0] <= sat_add32(sum_c_q[0], prod[24:0]);
				OP_MG: sum_c_q[1] <= sat_add32(sum_c_q[1], prod[24:0]);
				OP_MB: begin
					sum_c_q[2] <= sat_add32(sum_c_q[2], prod[24:0]);
					sum_w_q    <= sw_sum[24] ? 24'hFF_FFFF : sw_sum[23:0];
				end
				OP_OUT: begin
					for (int i = 0; i < 3; i++) begin
						sum_c_q[i] <= '0;
					end
					sum_w_q     <= '0;
					out_valid_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: design/interp_kernel_tap_accumulator.sv
// Top level of the interpolation kernel tap accumulator.
// Instantiates ikta_ctrl and ikta_dp; types and codes come from ikta_pkg.

// The block takes one neighbour tap per transfer on the input channel and builds a
// separable kernel weight in Q1.16 from the two Q4.12 offsets, using bilinear,
// cubic, Lanczos-2 or cubic B-spline kernels, with the area-patch factor in
// square-to-hex direction or the radius test in hex-to-square direction. Weighted
// colour sums and the weight sum accumulate until the tap marked last_tap, which
// yields one transfer of rounded, normalized RGB saturated at 255 (all zero if no
// weight was gathered). A tap that contributes occupies the block while every
// product of the kernel evaluation, tap weight, patch factors and three colour
// products goes through one shared multiplier in sequence; a tap that is skipped
// takes only the load step. A last tap then adds the three-lane divider (nine
// quotient steps) and the output load. Input is taken while a finished result
// still waits in the output register. Registers may be written only while the
// block is idle; the configuration channel is always ready.
module interp_kernel_tap_accumulator import ikta_pkg::*; #(
	parameter int MAX_TAPS = 49
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  ikta_in_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output ikta_out_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_data
);

	ikta_cmd_t  cmd;
	ikta_stat_t stat;

	// Register writes are never back-pressured.
	assign cfg_ready = 1'b1;

	ikta_ctrl #(
		.MAX_TAPS(MAX_TAPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ikta_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (in_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

`ifndef NO_ASSERTIONS
	// An accepted tap must be captured by the datapath in the same cycle.
	a_load_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> (cmd.op == OP_LOAD))
		else $error("accepted tap not loaded");

	// A new result is never written over one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_OUT) |-> (!out_valid || out_ready))
		else $error("result overwritten");

	// A result appears only after the output load step.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.op == OP_OUT))
		else $error("result without output load");
`endif

endmodule
